FILE: sv/lcl_pkg.sv
// Shared types and constants for the line command LED control unit.
package lcl_pkg;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam int ON_LEN     = 6;
    localparam int OFF_LEN    = 7;
    localparam int TOGGLE_LEN = 6;

    // Longest command plus one; the match position saturates here.
    localparam logic [3:0] POS_MAX = 4'd8;

    localparam logic [7:0] PAT_ON     [0:7] = '{8'h4C, 8'h45, 8'h44, 8'h20,
                                                8'h4F, 8'h4E, 8'h00, 8'h00};
    localparam logic [7:0] PAT_OFF    [0:7] = '{8'h4C, 8'h45, 8'h44, 8'h20,
                                                8'h4F, 8'h46, 8'h46, 8'h00};
    localparam logic [7:0] PAT_TOGGLE [0:7] = '{8'h54, 8'h4F, 8'h47, 8'h47,
                                                8'h4C, 8'h45, 8'h00, 8'h00};

    typedef enum logic [1:0] {
        CMD_LED_ON  = 2'd0,
        CMD_LED_OFF = 2'd1,
        CMD_TOGGLE  = 2'd2,
        CMD_UNKNOWN = 2'd3
    } cmd_code_t;

    // Byte held in the input register, offered to the line tracker.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rx_item_t;

endpackage

FILE: sv/lcl_in_stage.sv
// Input register: holds one received byte until the line tracker takes it.
module lcl_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output lcl_pkg::rx_item_t item,
    input  logic              item_take
);
    import lcl_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

FILE: sv/lcl_line_core.sv
// Line tracker: running command match, LED state and result register.
module lcl_line_core #(
    parameter int LINE_BYTES = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcl_pkg::rx_item_t item,
    output logic              item_take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_command_code,
    output logic              m_led_level
);
    import lcl_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);
    localparam logic [LW-1:0] DEPTH = LW'(LINE_BYTES - 1);

    logic [LW-1:0] len_reg,   len_next;
    logic [3:0]    pos_reg,   pos_next;
    logic          nul_reg,   nul_next;
    logic          on_reg,    on_next;
    logic          off_reg,   off_next;
    logic          tog_reg,   tog_next;
    logic          led_reg,   led_next;
    logic          valid_reg, valid_next;
    cmd_code_t     code_reg,  code_next;
    logic          level_reg, level_next;

    logic is_eol;
    logic out_load;
    logic hit_on, hit_off, hit_tog;

    assign is_eol    = (item.data == CHAR_LF) || (item.data == CHAR_CR);
    assign item_take = item.valid && (!valid_reg || m_ready);
    assign out_load  = item_take && is_eol && (len_reg != '0);

    // Compared text ends at the first NUL or when the line reaches its length limit.
    assign hit_on  = on_reg  && (pos_reg == 4'(ON_LEN));
    assign hit_off = off_reg && (pos_reg == 4'(OFF_LEN));
    assign hit_tog = tog_reg && (pos_reg == 4'(TOGGLE_LEN));

    always_comb begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        nul_next   = nul_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        tog_next   = tog_reg;
        led_next   = led_reg;
        code_next  = code_reg;
        level_next = level_reg;
        valid_next = (valid_reg && !m_ready) ? 1'b1 : 1'b0;

        if (item_take) begin
            if (is_eol) begin
                if (len_reg != '0) begin
                    if (hit_on) begin
                        code_next = CMD_LED_ON;
                        led_next  = 1'b1;
                    end else if (hit_off) begin
                        code_next = CMD_LED_OFF;
                        led_next  = 1'b0;
                    end else if (hit_tog) begin
                        code_next = CMD_TOGGLE;
                        led_next  = !led_reg;
                    end else begin
                        code_next = CMD_UNKNOWN;
                    end
                    level_next = led_next;
                    valid_next = 1'b1;
                    len_next   = '0;
                    pos_next   = '0;
                    nul_next   = 1'b0;
                    on_next    = 1'b1;
                    off_next   = 1'b1;
                    tog_next   = 1'b1;
                end
            end else if (len_reg < DEPTH) begin
                len_next = len_reg + 1'b1;
                if (!nul_reg) begin
                    if (item.data == CHAR_NUL) begin
                        nul_next = 1'b1;
                    end else begin
                        on_next  = on_reg && (pos_reg < 4'(ON_LEN)) &&
                                   (item.data == PAT_ON[pos_reg[2:0]]);
                        off_next = off_reg && (pos_reg < 4'(OFF_LEN)) &&
                                   (item.data == PAT_OFF[pos_reg[2:0]]);
                        tog_next = tog_reg && (pos_reg < 4'(TOGGLE_LEN)) &&
                                   (item.data == PAT_TOGGLE[pos_reg[2:0]]);
                        if (pos_reg != POS_MAX) begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            pos_reg   <= '0;
            nul_reg   <= 1'b0;
            on_reg    <= 1'b1;
            off_reg   <= 1'b1;
            tog_reg   <= 1'b1;
            led_reg   <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            nul_reg   <= nul_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            tog_reg   <= tog_next;
            led_reg   <= led_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        level_reg <= level_next;
    end

    assign m_valid        = valid_reg;
    assign m_command_code = code_reg;
    assign m_led_level    = level_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("match position past saturation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_MAX) |-> !(on_reg || off_reg || tog_reg))
        else $error("command flag alive past longest command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (len_reg == '0) && valid_reg && (m_led_level == led_reg))
        else $error("line end did not restart line or publish LED");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && is_eol && (len_reg == '0)) |=> $stable(led_reg))
        else $error("empty line changed LED");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg != '0) |-> (len_reg >= LW'(pos_reg)))
        else $error("match position ahead of line length");

endmodule

FILE: sv/line_command_led_control_unit.sv
// Top level of the line command LED control unit.
// Received bytes enter on the s_ channel, one transfer per cycle while no result is held back
// by m_ready; each byte goes through an input register and then match logic into the result
// register, so a result is offered once the line-ending CR or LF has passed both registers.
// While a result waits on m_ready the byte in the input register is held and s_ready
// stays low until the result transfers.
// Lines hold up to LINE_BYTES-1 characters, later ones are dropped; a NUL ends the
// compared text. "LED ON", "LED OFF" and "TOGGLE" set, clear or invert the LED (lit
// after reset); anything else reports unknown. CR or LF on an empty line is ignored.
// The line text is not stored: the commands are matched as the bytes arrive.
module line_command_led_control_unit #(
    parameter int LINE_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_command_code,
    output logic       m_led_level
);
    import lcl_pkg::*;

    rx_item_t item;
    logic     item_take;

    lcl_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .item      (item),
        .item_take (item_take)
    );

    lcl_line_core #(
        .LINE_BYTES (LINE_BYTES)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item           (item),
        .item_take      (item_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_code (m_command_code),
        .m_led_level    (m_led_level)
    );

endmodule
